FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: sv/tlvp_pkg.sv
// ----------------------------------------------------------------------------
// tlvp_pkg
// Types and constants shared by the nested TLV stream parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvp_pkg;

	// deepest level that a container may open
	localparam int MAX_DEPTH = 8;
	// bits of the level index (levels 0 .. MAX_DEPTH)
	localparam int IDX_W = $clog2(MAX_DEPTH + 1);
	// width of the nest_level result field
	localparam int LVL_W = 4;
	localparam int LEN_W = 32;
	// header: 2-byte tag and 4-byte length
	localparam int HDR_BYTES = 6;
	localparam int HCNT_W = 3;
	localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HDR_BYTES - 1);
	// earlier header bytes kept while the last one arrives
	localparam int HDR_KEEP_W = 8 * (HDR_BYTES - 1);
	// tag bit that marks a container
	localparam int CONTAINER_BIT = 15;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_VALUE,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             start_of_message;
		logic [LEN_W-1:0] message_length;
	} item_t;

	typedef struct packed {
		logic [LVL_W-1:0] nest_level;
		logic [7:0]       value_byte;
		logic             has_byte;
		logic             last_of_leaf;
		logic             depth_overflow;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/tlvp_in_reg.sv
// ----------------------------------------------------------------------------
// tlvp_in_reg
// Input register: holds one accepted byte until the parser core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvp_in_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire tlvp_pkg::item_t in_item,
	output logic                item_valid,
	input  wire logic           item_take,
	output tlvp_pkg::item_t     item
);

	logic            valid_s1;
	tlvp_pkg::item_t item_s1;

	// take a new transfer when empty or when the held item moves on
	assign in_ready   = !valid_s1 || item_take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// hold valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// load payload on each transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

FILE: sv/tlvp_core.sv
// ----------------------------------------------------------------------------
// tlvp_core
// Parser state and its combinational per-byte update: header collection,
// leaf value bytes, skips and the level stack of remaining byte counts.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tlvp_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire tlvp_pkg::item_t item,
	output logic                 emit,
	output tlvp_pkg::result_t    res
);

	localparam int NLVL = tlvp_pkg::MAX_DEPTH + 1;
	localparam int IW   = tlvp_pkg::IDX_W;
	localparam int LW   = tlvp_pkg::LEN_W;
	localparam logic [IW-1:0] DEPTH_TOP = IW'(tlvp_pkg::MAX_DEPTH);
	localparam logic [LW-1:0] HDR_LEN   = LW'(tlvp_pkg::HDR_BYTES);

	// state registers
	logic [LW-1:0]                    rem_q [NLVL];
	logic [IW-1:0]                    depth_q;
	logic [tlvp_pkg::HDR_KEEP_W-1:0]  hdr_q;
	logic [tlvp_pkg::HCNT_W-1:0]      hcnt_q;
	tlvp_pkg::phase_t                 phase_q;
	logic [LW-1:0]                    vrem_q;

	// state as seen after a start of message
	logic [LW-1:0]                    e_rem [NLVL];
	logic [IW-1:0]                    e_depth;
	logic [tlvp_pkg::HDR_KEEP_W-1:0]  e_hdr;
	logic [tlvp_pkg::HCNT_W-1:0]      e_hcnt;
	tlvp_pkg::phase_t                 e_phase;
	logic [LW-1:0]                    e_vrem;

	// state after the byte, before and after settling at a record boundary
	logic [LW-1:0]                    n_rem [NLVL];
	logic [IW-1:0]                    n_depth;
	logic [tlvp_pkg::HDR_KEEP_W-1:0]  n_hdr;
	logic [tlvp_pkg::HCNT_W-1:0]      n_hcnt;
	tlvp_pkg::phase_t                 n_phase;
	logic [LW-1:0]                    n_vrem;
	logic                             settle_req;

	logic [LW-1:0]                    f_rem [NLVL];
	logic [IW-1:0]                    f_depth;
	tlvp_pkg::phase_t                 f_phase;
	logic [LW-1:0]                    f_vrem;

	// datapath helpers
	logic [LW-1:0]                    rem_cur;
	logic [LW-1:0]                    rem_dec;
	logic [47:0]                      hdr_word;
	logic [15:0]                      tag;
	logic [LW-1:0]                    len;
	logic [LW:0]                      diff;
	logic                             overrun;
	logic [LW-1:0]                    vdec;
	logic [IW-1:0]                    d_inc;
	logic                             found;
	logic [IW-1:0]                    sel;
	logic [LW-1:0]                    sel_rem;

	// apply start of message: load top-level length, settle at once
	always_comb begin
		e_depth = depth_q;
		e_hdr   = hdr_q;
		e_hcnt  = hcnt_q;
		e_phase = phase_q;
		e_vrem  = vrem_q;
		for (int k = 0; k < NLVL; k++) begin
			e_rem[k] = rem_q[k];
		end
		if (item.start_of_message) begin
			for (int k = 0; k < NLVL; k++) begin
				e_rem[k] = '0;
			end
			e_depth = '0;
			e_hdr   = '0;
			e_hcnt  = '0;
			e_vrem  = '0;
			if (item.message_length == '0) begin
				e_phase = tlvp_pkg::PH_IDLE;
			end else if (item.message_length < HDR_LEN) begin
				e_phase = tlvp_pkg::PH_SKIP;
				e_vrem  = item.message_length;
			end else begin
				e_phase  = tlvp_pkg::PH_HEADER;
				e_rem[0] = item.message_length;
			end
		end
	end

	// shared arithmetic on the current level and the header word
	always_comb begin
		rem_cur  = e_rem[e_depth];
		rem_dec  = rem_cur - LW'(|rem_cur);
		hdr_word = {e_hdr, item.data_byte};
		tag      = hdr_word[47:32];
		len      = hdr_word[31:0];
		diff     = {1'b0, rem_dec} - {1'b0, len};
		overrun  = diff[LW];
		vdec     = e_vrem - LW'(|e_vrem);
		d_inc    = e_depth + 1'b1;
	end

	// consume one byte
	always_comb begin
		n_depth    = e_depth;
		n_hdr      = e_hdr;
		n_hcnt     = e_hcnt;
		n_phase    = e_phase;
		n_vrem     = e_vrem;
		settle_req = 1'b0;
		emit       = 1'b0;
		res        = '0;
		for (int k = 0; k < NLVL; k++) begin
			n_rem[k] = e_rem[k];
		end
		res.nest_level = tlvp_pkg::LVL_W'(e_depth);
		case (e_phase)
			tlvp_pkg::PH_HEADER: begin
				n_hdr = hdr_word[tlvp_pkg::HDR_KEEP_W-1:0];
				n_rem[e_depth] = rem_dec;
				if (e_hcnt != tlvp_pkg::HCNT_LAST) begin
					n_hcnt = e_hcnt + 1'b1;
				end else begin
					n_hcnt = '0;
					if (overrun) begin
						// record runs past its level: drop the rest of the level
						n_rem[e_depth] = '0;
						n_vrem = rem_dec;
						if (rem_dec != '0) begin
							n_phase = tlvp_pkg::PH_SKIP;
						end else begin
							settle_req = 1'b1;
						end
					end else begin
						n_rem[e_depth] = diff[LW-1:0];
						if (tag[tlvp_pkg::CONTAINER_BIT]) begin
							if (e_depth != DEPTH_TOP) begin
								// open one level deeper
								n_depth = d_inc;
								for (int k = 0; k < NLVL; k++) begin
									if (IW'(k) == d_inc) begin
										n_rem[k] = len;
									end
								end
								settle_req = 1'b1;
							end else begin
								// too deep: report, then skip the value
								emit = 1'b1;
								res.depth_overflow = 1'b1;
								if (len != '0) begin
									n_vrem  = len;
									n_phase = tlvp_pkg::PH_SKIP;
								end else begin
									settle_req = 1'b1;
								end
							end
						end else if (len == '0) begin
							// empty leaf
							emit = 1'b1;
							res.last_of_leaf = 1'b1;
							settle_req = 1'b1;
						end else begin
							n_vrem  = len;
							n_phase = tlvp_pkg::PH_VALUE;
						end
					end
				end
			end
			tlvp_pkg::PH_VALUE: begin
				n_vrem = vdec;
				emit = 1'b1;
				res.value_byte   = item.data_byte;
				res.has_byte     = 1'b1;
				res.last_of_leaf = (vdec == '0);
				if (vdec == '0) begin
					n_phase    = tlvp_pkg::PH_HEADER;
					settle_req = 1'b1;
				end
			end
			tlvp_pkg::PH_SKIP: begin
				n_vrem = vdec;
				if (vdec == '0) begin
					n_phase    = tlvp_pkg::PH_HEADER;
					settle_req = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// find the innermost open level at or above the current one
	always_comb begin
		found   = 1'b0;
		sel     = '0;
		sel_rem = '0;
		for (int k = 0; k < NLVL; k++) begin
			if ((IW'(k) <= n_depth) && (n_rem[k] != '0)) begin
				found   = 1'b1;
				sel     = IW'(k);
				sel_rem = n_rem[k];
			end
		end
	end

	// settle at a record boundary: leave used-up levels, skip short tails
	always_comb begin
		f_depth = n_depth;
		f_phase = n_phase;
		f_vrem  = n_vrem;
		for (int k = 0; k < NLVL; k++) begin
			f_rem[k] = n_rem[k];
		end
		if (settle_req) begin
			if (!found) begin
				f_depth = '0;
				f_phase = tlvp_pkg::PH_IDLE;
			end else begin
				f_depth = sel;
				if (sel_rem < HDR_LEN) begin
					f_vrem     = sel_rem;
					f_rem[sel] = '0;
					f_phase    = tlvp_pkg::PH_SKIP;
				end
			end
		end
	end

	// advance state on each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NLVL; k++) begin
				rem_q[k] <= '0;
			end
			depth_q <= '0;
			hdr_q   <= '0;
			hcnt_q  <= '0;
			phase_q <= tlvp_pkg::PH_IDLE;
			vrem_q  <= '0;
		end else if (step) begin
			for (int k = 0; k < NLVL; k++) begin
				rem_q[k] <= f_rem[k];
			end
			depth_q <= f_depth;
			hdr_q   <= n_hdr;
			hcnt_q  <= n_hcnt;
			phase_q <= f_phase;
			vrem_q  <= f_vrem;
		end
	end

	`ASSERT_ALWAYS(a_depth_range, clk, arst_n, depth_q <= DEPTH_TOP, "depth beyond maximum")
	`ASSERT_IMPLY(a_hcnt_header, clk, arst_n, hcnt_q != '0, phase_q == tlvp_pkg::PH_HEADER, "partial header outside header phase")
	`ASSERT_IMPLY(a_value_left, clk, arst_n, phase_q == tlvp_pkg::PH_VALUE, vrem_q != '0, "value phase with no bytes left")
	`ASSERT_IMPLY(a_skip_left, clk, arst_n, phase_q == tlvp_pkg::PH_SKIP, vrem_q != '0, "skip phase with no bytes left")

endmodule

`default_nettype wire

FILE: sv/tlvp_out_reg.sv
// ----------------------------------------------------------------------------
// tlvp_out_reg
// Result register: holds one result until the output transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvp_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_valid,
	input  wire tlvp_pkg::result_t res_in,
	output logic                   slot_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tlvp_pkg::result_t      res_out
);

	logic              valid_q;
	tlvp_pkg::result_t res_q;

	// free when empty or when the held result leaves this cycle
	assign slot_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign res_out    = res_q;

	// hold valid until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_ready) begin
			valid_q <= res_valid;
		end
	end

	// load a new result
	always_ff @(posedge clk) begin
		if (slot_ready && res_valid) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire

FILE: sv/nested_tlv_stream_parser_top.sv
// ----------------------------------------------------------------------------
// nested_tlv_stream_parser_top
// Byte-stream parser for nested tag/length/value records with 16-bit tags
// and 32-bit lengths; emits leaf value bytes with their nesting level.
// ----------------------------------------------------------------------------
// The parser takes one message byte per clock and gives at most one result
// per byte, so it sustains one byte per cycle in both directions while
// out_ready is held high; a result waiting on a low out_ready stalls the core.
// A byte passes through the input register into the core, and its result is
// registered in the result register when that register is free.
// The whole per-byte state update, including popping any number of finished
// levels, is done combinationally in the core, so that loop sets the rate.
// One byte can be taken into the input register while a result still waits
// on the output. Containers nest up to eight levels deep.
`default_nettype none

module nested_tlv_stream_parser_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        start_of_message,
	input  wire logic [tlvp_pkg::LEN_W-1:0]  message_length,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [tlvp_pkg::LVL_W-1:0]       nest_level,
	output logic [7:0]                       value_byte,
	output logic                             has_byte,
	output logic                             last_of_leaf,
	output logic                             depth_overflow
);

	tlvp_pkg::item_t   in_item;
	tlvp_pkg::item_t   item;
	logic              item_valid;
	logic              slot_ready;
	logic              step;
	logic              emit;
	tlvp_pkg::result_t res;
	tlvp_pkg::result_t res_out;

	// pack input fields
	assign in_item.data_byte        = data_byte;
	assign in_item.start_of_message = start_of_message;
	assign in_item.message_length   = message_length;

	// consume the held byte when the result slot can take its result
	assign step = item_valid && slot_ready;

	tlvp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_take  (slot_ready),
		.item       (item)
	);

	tlvp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item),
		.emit   (emit),
		.res    (res)
	);

	tlvp_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (step && emit),
		.res_in     (res),
		.slot_ready (slot_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res_out    (res_out)
	);

	// unpack result fields
	assign nest_level     = res_out.nest_level;
	assign value_byte     = res_out.value_byte;
	assign has_byte       = res_out.has_byte;
	assign last_of_leaf   = res_out.last_of_leaf;
	assign depth_overflow = res_out.depth_overflow;

endmodule

`default_nettype wire
